// ===== sv/swrc_pkg.sv =====
// Shared types, codes and reset values of the stop-and-wait retransmit controller.
`default_nettype none

package swrc_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;

  localparam int unsigned TID_W       = 32;
  localparam int unsigned BASE_TO_W   = 16;
  localparam int unsigned RETRY_W     = 8;
  localparam int unsigned MULT_W      = 8;
  localparam int unsigned IDLE_TO_W   = 16;
  localparam int unsigned TIMEOUT_W   = 32;
  localparam int unsigned CFG_ADDR_W  = 2;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned IN_DATA_W   = 40;
  localparam int unsigned IN_USER_W   = 2;
  localparam int unsigned OUT_DATA_W  = 40;
  localparam int unsigned OUT_USER_W  = 3;

  localparam logic [BASE_TO_W-1:0] BASE_TO_RST = 16'd500;
  localparam logic [RETRY_W-1:0]   RETRY_RST   = 8'd7;
  localparam logic [MULT_W-1:0]    MULT_RST    = 8'd16;
  localparam logic [IDLE_TO_W-1:0] IDLE_TO_RST = 16'd5000;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_BASE_TIMEOUT = 2'd0,
    REG_RETRY_LIMIT  = 2'd1,
    REG_LAST_MULT    = 2'd2,
    REG_IDLE_TIMEOUT = 2'd3
  } reg_idx_t;

  typedef enum logic [IN_USER_W-1:0] {
    FUNC_SEND = 2'd0,
    FUNC_ACK  = 2'd1,
    FUNC_DATA = 2'd2,
    FUNC_TICK = 2'd3
  } func_t;

  typedef enum logic [OUT_USER_W-1:0] {
    ACT_NONE        = 3'd0,
    ACT_TX          = 3'd1,
    ACT_RETX        = 3'd2,
    ACT_ACK         = 3'd3,
    ACT_DROP_CLOSED = 3'd4,
    ACT_DROP_FULL   = 3'd5,
    ACT_CLOSED      = 3'd6
  } action_t;

endpackage

`default_nettype wire

// ===== sv/stop_and_wait_retransmit_controller.sv =====
// Stop-and-wait retransmit controller: id queue, retry backoff and idle timer.
//
//   Channel   Direction  Handshake              Contents
//   in_*      in         in_tvalid/in_tready    tuser: func; tdata: rx_tid, body_nonempty
//   out_*     out        out_tvalid/out_tready  tuser: action; tdata: tid, deliver, link
//   cfg_*     in         cfg_we (no wait)       cfg_addr register index, cfg_wdata value
//
// Every transaction is worked out in the cycle it is accepted and its result is
// registered, so the result appears in the next cycle and one item a cycle is taken.
// The single output register sets the rate: a new item is taken while the held
// result is being taken, and the input stalls only while the output is stalled.
// Reset (rst_n low, synchronous) restores the register defaults, opens the link
// and empties the queue; no clearing pass is needed.
// The pending ids are always consecutive, so the front id follows from the last
// id issued and the queue fill count, and no id storage is kept.
`default_nettype none

module stop_and_wait_retransmit_controller #(
  parameter int unsigned QUEUE_DEPTH = swrc_pkg::QUEUE_DEPTH
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // Configuration write port.
  input  wire logic                                cfg_we,
  input  wire logic [swrc_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  wire logic [swrc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  // Input stream.
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // [31:0] rx_tid, [32] body_nonempty, [39:33] zero
  input  wire logic [swrc_pkg::IN_DATA_W-1:0]      in_tdata,
  // [1:0] func
  input  wire logic [swrc_pkg::IN_USER_W-1:0]      in_tuser,
  // Result stream.
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // [31:0] out_tid, [32] deliver, [33] link_is_open, [39:34] zero
  output logic [swrc_pkg::OUT_DATA_W-1:0]          out_tdata,
  // [2:0] action
  output logic [swrc_pkg::OUT_USER_W-1:0]          out_tuser
);

  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned TidW = swrc_pkg::TID_W;
  localparam int unsigned ToW  = swrc_pkg::TIMEOUT_W;

  // Configuration registers.
  logic [swrc_pkg::BASE_TO_W-1:0] base_to_r;
  logic [swrc_pkg::RETRY_W-1:0]   retry_lim_r;
  logic [swrc_pkg::MULT_W-1:0]    last_mult_r;
  logic [swrc_pkg::IDLE_TO_W-1:0] idle_to_r;

  // Protocol state.
  logic                           link_open_r, link_open_nxt;
  logic [TidW-1:0]                last_tid_r, last_tid_nxt;
  logic [CntW-1:0]                q_count_r, q_count_nxt;
  logic                           in_flight_r, in_flight_nxt;
  logic [swrc_pkg::RETRY_W-1:0]   send_cnt_r, send_cnt_nxt;
  logic [ToW-1:0]                 cur_to_r, cur_to_nxt;
  logic [ToW-1:0]                 retx_cnt_r, retx_cnt_nxt;
  logic [swrc_pkg::IDLE_TO_W-1:0] idle_cnt_r, idle_cnt_nxt;
  logic                           idle_run_r, idle_run_nxt;

  // Output register.
  logic                           out_valid_r;
  logic [swrc_pkg::OUT_DATA_W-1:0] out_tdata_r, out_tdata_nxt;
  logic [swrc_pkg::OUT_USER_W-1:0] out_tuser_r;
  swrc_pkg::action_t              action_nxt;

  logic                           accept;
  swrc_pkg::func_t                func;
  logic [TidW-1:0]                rx_tid;
  logic                           body_nonempty;
  logic [TidW-1:0]                front_id;
  logic [TidW-1:0]                tid_nxt;
  logic                           deliver_nxt;
  logic [ToW-1:0]                 last_wait;
  logic [ToW-1:0]                 doubled_to;
  logic [swrc_pkg::IDLE_TO_W-1:0] idle_load;
  logic [ToW-1:0]                 idle_dec;
  logic                           retx_expired;
  logic                           pop;

  assign in_tready     = !out_valid_r || out_tready;
  assign accept        = in_tvalid && in_tready;
  assign func          = swrc_pkg::func_t'(in_tuser);
  assign rx_tid        = in_tdata[TidW-1:0];
  assign body_nonempty = in_tdata[TidW];

  // Oldest pending id; equals the next id to issue when the queue is empty.
  assign front_id   = last_tid_r - TidW'(q_count_r) + TidW'(1);
  assign last_wait  = ToW'(base_to_r) * ToW'(last_mult_r);
  assign doubled_to = cur_to_r[ToW-1] ? '1 : {cur_to_r[ToW-2:0], 1'b0};
  assign idle_load  = (idle_to_r == '0) ? swrc_pkg::IDLE_TO_W'(1) : idle_to_r;
  assign idle_dec   = ToW'(idle_cnt_r) - ToW'(1);

  always_comb begin
    link_open_nxt = link_open_r;
    last_tid_nxt  = last_tid_r;
    q_count_nxt   = q_count_r;
    in_flight_nxt = in_flight_r;
    send_cnt_nxt  = send_cnt_r;
    cur_to_nxt    = cur_to_r;
    retx_cnt_nxt  = retx_cnt_r;
    idle_cnt_nxt  = idle_cnt_r;
    idle_run_nxt  = idle_run_r;
    action_nxt    = swrc_pkg::ACT_NONE;
    tid_nxt       = '0;
    deliver_nxt   = 1'b0;
    retx_expired  = 1'b0;
    pop           = 1'b0;

    case (func)
      swrc_pkg::FUNC_SEND: begin
        if (!link_open_r) begin
          action_nxt = swrc_pkg::ACT_DROP_CLOSED;
        end else if (q_count_r >= CntW'(QUEUE_DEPTH)) begin
          action_nxt = swrc_pkg::ACT_DROP_FULL;
        end else begin
          last_tid_nxt = last_tid_r + TidW'(1);
          q_count_nxt  = q_count_r + CntW'(1);
          if (!in_flight_r) begin
            in_flight_nxt = 1'b1;
            send_cnt_nxt  = send_cnt_r + swrc_pkg::RETRY_W'(1);
            retx_cnt_nxt  = (cur_to_r == '0) ? ToW'(1) : cur_to_r;
            tid_nxt       = front_id;
            action_nxt    = swrc_pkg::ACT_TX;
          end
        end
      end
      swrc_pkg::FUNC_ACK: begin
        if (link_open_r) begin
          idle_cnt_nxt = idle_load;
          idle_run_nxt = 1'b1;
          pop = (q_count_r != '0) && (front_id == rx_tid);
          if (pop) begin
            q_count_nxt   = q_count_r - CntW'(1);
            retx_cnt_nxt  = '0;
            send_cnt_nxt  = '0;
            cur_to_nxt    = ToW'(base_to_r);
            in_flight_nxt = 1'b0;
          end
          // The next entry goes out at once if one is waiting.
          if ((!in_flight_nxt) && (q_count_nxt != '0)) begin
            in_flight_nxt = 1'b1;
            send_cnt_nxt  = send_cnt_nxt + swrc_pkg::RETRY_W'(1);
            retx_cnt_nxt  = (cur_to_nxt == '0) ? ToW'(1) : cur_to_nxt;
            tid_nxt       = front_id + TidW'(pop);
            action_nxt    = swrc_pkg::ACT_TX;
          end
        end
      end
      swrc_pkg::FUNC_DATA: begin
        if (link_open_r) begin
          idle_cnt_nxt = idle_load;
          idle_run_nxt = 1'b1;
          deliver_nxt  = body_nonempty;
          tid_nxt      = rx_tid;
          action_nxt   = swrc_pkg::ACT_ACK;
        end
      end
      swrc_pkg::FUNC_TICK: begin
        if (retx_cnt_r != '0) begin
          retx_cnt_nxt = retx_cnt_r - ToW'(1);
          retx_expired = (retx_cnt_r == ToW'(1));
        end
        // The idle expiry is looked at first and wins over a retransmit expiry.
        if (idle_run_r) begin
          if (idle_cnt_r != '0) begin
            idle_cnt_nxt = idle_dec[swrc_pkg::IDLE_TO_W-1:0];
          end
          if (idle_cnt_nxt == '0) begin
            idle_run_nxt = 1'b0;
            if (link_open_r) begin
              action_nxt = swrc_pkg::ACT_CLOSED;
            end
            link_open_nxt = 1'b0;
          end
        end
        if (retx_expired && link_open_nxt) begin
          if (send_cnt_r >= retry_lim_r) begin
            link_open_nxt = 1'b0;
            action_nxt    = swrc_pkg::ACT_CLOSED;
          end else begin
            if (({1'b0, send_cnt_r} + 9'd1) == {1'b0, retry_lim_r}) begin
              cur_to_nxt = last_wait;
            end else begin
              cur_to_nxt = doubled_to;
            end
            if (q_count_r != '0) begin
              send_cnt_nxt = send_cnt_r + swrc_pkg::RETRY_W'(1);
              retx_cnt_nxt = (cur_to_nxt == '0) ? ToW'(1) : cur_to_nxt;
              tid_nxt      = front_id;
              action_nxt   = swrc_pkg::ACT_RETX;
            end
          end
        end
      end
      default: begin
        action_nxt = swrc_pkg::ACT_NONE;
      end
    endcase
  end

  always_comb begin
    out_tdata_nxt               = '0;
    out_tdata_nxt[TidW-1:0]     = tid_nxt;
    out_tdata_nxt[TidW]         = deliver_nxt;
    out_tdata_nxt[TidW+1]       = link_open_nxt;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_to_r   <= swrc_pkg::BASE_TO_RST;
      retry_lim_r <= swrc_pkg::RETRY_RST;
      last_mult_r <= swrc_pkg::MULT_RST;
      idle_to_r   <= swrc_pkg::IDLE_TO_RST;
    end else if (cfg_we) begin
      case (swrc_pkg::reg_idx_t'(cfg_addr))
        swrc_pkg::REG_BASE_TIMEOUT: base_to_r   <= cfg_wdata;
        swrc_pkg::REG_RETRY_LIMIT:  retry_lim_r <= cfg_wdata[swrc_pkg::RETRY_W-1:0];
        swrc_pkg::REG_LAST_MULT:    last_mult_r <= cfg_wdata[swrc_pkg::MULT_W-1:0];
        swrc_pkg::REG_IDLE_TIMEOUT: idle_to_r   <= cfg_wdata;
        default:                    base_to_r   <= base_to_r;
      endcase
    end
  end

  // Protocol state moves only on an accepted transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_open_r <= 1'b1;
      last_tid_r  <= '0;
      q_count_r   <= '0;
      in_flight_r <= 1'b0;
      send_cnt_r  <= '0;
      cur_to_r    <= ToW'(swrc_pkg::BASE_TO_RST);
      retx_cnt_r  <= '0;
      idle_cnt_r  <= '0;
      idle_run_r  <= 1'b0;
    end else if (accept) begin
      link_open_r <= link_open_nxt;
      last_tid_r  <= last_tid_nxt;
      q_count_r   <= q_count_nxt;
      in_flight_r <= in_flight_nxt;
      send_cnt_r  <= send_cnt_nxt;
      cur_to_r    <= cur_to_nxt;
      retx_cnt_r  <= retx_cnt_nxt;
      idle_cnt_r  <= idle_cnt_nxt;
      idle_run_r  <= idle_run_nxt;
    end
  end

  // Output register; payload carries no reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_tdata_r <= out_tdata_nxt;
      out_tuser_r <= action_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // An entry in flight means the queue holds it.
  a_flight_has_entry: assert property (@(posedge clk) disable iff (!rst_n)
    in_flight_r |-> (q_count_r != '0))
    else $error("entry in flight with an empty queue");

  // The retransmit timer only runs for an entry in flight.
  a_timer_needs_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (retx_cnt_r != '0) |-> in_flight_r)
    else $error("retransmit timer running with nothing in flight");

  // Once closed, the link stays closed until reset.
  a_closed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    !link_open_r |=> !link_open_r)
    else $error("link reopened without reset");

  // The fill count never passes the queue depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count_r <= CntW'(QUEUE_DEPTH))
    else $error("queue fill count beyond depth");

  // A transmission is only reported on an open link.
  a_tx_on_open: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && ((out_tuser_r == swrc_pkg::ACT_TX) ||
                     (out_tuser_r == swrc_pkg::ACT_RETX))) |-> out_tdata_r[TidW+1])
    else $error("transmission reported on a closed link");

endmodule

`default_nettype wire

// ===== verif/tb_stop_and_wait_retransmit_controller.sv =====
// Self-checking testbench for the stop-and-wait retransmit controller.
module tb_stop_and_wait_retransmit_controller;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HEAD_W = $clog2(swrc_pkg::QUEUE_DEPTH);

  typedef struct packed {
    swrc_pkg::action_t act;
    logic [31:0]       tid;
    logic              deliver;
    logic              link;
  } link_result_t;

  typedef enum int {
    CLOSE_BY_IDLE,
    CLOSE_BY_RETRY,
    CLOSE_BY_BOTH,
    CLOSE_BY_LOWERED_LIMIT
  } close_mode_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            cfg_we = 1'b0;
  logic [swrc_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [swrc_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [swrc_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  logic [swrc_pkg::IN_USER_W-1:0]  in_tuser = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [swrc_pkg::OUT_DATA_W-1:0] out_tdata;
  logic [swrc_pkg::OUT_USER_W-1:0] out_tuser;

  // Copy of the controller state and its registers, kept in step with accepted transactions.
  logic [15:0]       lk_base;
  logic [7:0]        lk_retry_limit;
  logic [7:0]        lk_mult;
  logic [15:0]       lk_idle_to;
  logic              lk_open;
  logic [31:0]       lk_last_tid;
  logic [31:0]       lk_ids [swrc_pkg::QUEUE_DEPTH];
  logic [HEAD_W-1:0] lk_head;
  logic [HEAD_W:0]   lk_count;
  logic              lk_in_flight;
  logic [7:0]        lk_sends;
  logic [31:0]       lk_timeout;
  logic [31:0]       lk_retx_left;
  logic [15:0]       lk_idle_left;
  logic              lk_idle_on;

  link_result_t awaited[$];
  int    snd_idle_pct = 16;
  int    rcv_idle_pct = 81;
  int    n_errors = 0;
  int    n_items = 0;
  int    n_checked = 0;
  int    n_retx = 0;
  int    n_full = 0;
  string close_how = "nothing";

  stop_and_wait_retransmit_controller u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #4 clk = ~clk;

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  function automatic void reset_link_model();
    lk_base        = swrc_pkg::BASE_TO_RST;
    lk_retry_limit = swrc_pkg::RETRY_RST;
    lk_mult        = swrc_pkg::MULT_RST;
    lk_idle_to     = swrc_pkg::IDLE_TO_RST;
    lk_open        = 1'b1;
    lk_last_tid    = '0;
    foreach (lk_ids[i]) lk_ids[i] = '0;
    lk_head        = '0;
    lk_count       = '0;
    lk_in_flight   = 1'b0;
    lk_sends       = '0;
    lk_timeout     = {16'd0, swrc_pkg::BASE_TO_RST};
    lk_retx_left   = '0;
    lk_idle_left   = '0;
    lk_idle_on     = 1'b0;
  endfunction

  function automatic logic [31:0] nonzero(input logic [31:0] v);
    return (v == 32'd0) ? 32'd1 : v;
  endfunction

  // Puts the front id on the wire when nothing is outstanding.
  function automatic bit launch_front(output logic [31:0] tid);
    tid = '0;
    if (lk_in_flight || lk_count == 0) return 1'b0;
    lk_in_flight = 1'b1;
    lk_sends     = lk_sends + 8'd1;
    lk_retx_left = nonzero(lk_timeout);
    tid          = lk_ids[lk_head];
    return 1'b1;
  endfunction

  function automatic void restart_idle_timer();
    lk_idle_left = (lk_idle_to == 16'd0) ? 16'd1 : lk_idle_to;
    lk_idle_on   = 1'b1;
  endfunction

  function automatic link_result_t predict_link_step(input swrc_pkg::func_t f,
                                                     input logic [31:0] rx_tid,
                                                     input logic body);
    link_result_t      r;
    logic [31:0]       tid;
    logic [HEAD_W-1:0] slot;
    logic              retx_due;
    r.act     = swrc_pkg::ACT_NONE;
    r.tid     = '0;
    r.deliver = 1'b0;
    case (f)
      swrc_pkg::FUNC_SEND: begin
        if (!lk_open) begin
          r.act = swrc_pkg::ACT_DROP_CLOSED;
        end else if (lk_count >= swrc_pkg::QUEUE_DEPTH) begin
          r.act = swrc_pkg::ACT_DROP_FULL;
        end else begin
          lk_last_tid  = lk_last_tid + 32'd1;
          slot         = lk_head + lk_count[HEAD_W-1:0];
          lk_ids[slot] = lk_last_tid;
          lk_count     = lk_count + 1'b1;
          if (launch_front(tid)) begin
            r.act = swrc_pkg::ACT_TX;
            r.tid = tid;
          end
        end
      end
      swrc_pkg::FUNC_ACK: begin
        if (lk_open) begin
          restart_idle_timer();
          if (lk_count != 0) begin
            if (lk_ids[lk_head] == rx_tid) begin
              lk_head      = lk_head + 1'b1;
              lk_count     = lk_count - 1'b1;
              lk_retx_left = '0;
              lk_sends     = '0;
              lk_timeout   = {16'd0, lk_base};
              lk_in_flight = 1'b0;
            end
          end
          if (launch_front(tid)) begin
            r.act = swrc_pkg::ACT_TX;
            r.tid = tid;
          end
        end
      end
      swrc_pkg::FUNC_DATA: begin
        if (lk_open) begin
          restart_idle_timer();
          r.deliver = body;
          r.act     = swrc_pkg::ACT_ACK;
          r.tid     = rx_tid;
        end
      end
      default: begin
        retx_due = 1'b0;
        if (lk_retx_left != 0) begin
          lk_retx_left = lk_retx_left - 32'd1;
          retx_due     = (lk_retx_left == 0);
        end
        if (lk_idle_on) begin
          if (lk_idle_left != 0) lk_idle_left = lk_idle_left - 16'd1;
          if (lk_idle_left == 0) begin
            lk_idle_on = 1'b0;
            if (lk_open) r.act = swrc_pkg::ACT_CLOSED;
            lk_open = 1'b0;
          end
        end
        // An idle expiry on the same tick has already closed the link, so the
        // retransmit expiry is simply lost.
        if (retx_due && lk_open) begin
          if (lk_sends >= lk_retry_limit) begin
            lk_open = 1'b0;
            r.act   = swrc_pkg::ACT_CLOSED;
          end else begin
            if ({1'b0, lk_sends} + 9'd1 == {1'b0, lk_retry_limit}) begin
              lk_timeout = lk_base * lk_mult;
            end else if (lk_timeout > 32'h7FFF_FFFF) begin
              lk_timeout = '1;
            end else begin
              lk_timeout = lk_timeout << 1;
            end
            if (lk_count != 0) begin
              lk_sends     = lk_sends + 8'd1;
              lk_retx_left = nonzero(lk_timeout);
              r.tid        = lk_ids[lk_head];
              r.act        = swrc_pkg::ACT_RETX;
            end
          end
        end
      end
    endcase
    r.link = lk_open;
    return r;
  endfunction

  function automatic logic [31:0] front_or_random();
    return (lk_count != 0) ? lk_ids[lk_head] : $urandom;
  endfunction

  function automatic bit tick_closes_link();
    if (!lk_open) return 1'b0;
    if (lk_idle_on && lk_idle_left <= 16'd1) return 1'b1;
    return (lk_retx_left == 32'd1 && lk_sends >= lk_retry_limit);
  endfunction

  always @(posedge clk) begin : check_results
    link_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (awaited.size() == 0) begin
        $error("unexpected result: action %0d, out_tid %0h", out_tuser, out_tdata[31:0]);
        n_errors++;
      end else begin
        want = awaited.pop_front();
        n_checked++;
        if (out_tuser !== want.act) begin
          $error("action: expected %0d, actual %0d", want.act, out_tuser);
          n_errors++;
        end
        if (out_tdata[31:0] !== want.tid) begin
          $error("out_tid: expected %0h, actual %0h", want.tid, out_tdata[31:0]);
          n_errors++;
        end
        if (out_tdata[32] !== want.deliver) begin
          $error("deliver: expected %0b, actual %0b", want.deliver, out_tdata[32]);
          n_errors++;
        end
        if (out_tdata[33] !== want.link) begin
          $error("link_is_open: expected %0b, actual %0b", want.link, out_tdata[33]);
          n_errors++;
        end
      end
    end
  end

  // Called and returns at a falling edge; the input channel is left idle.
  task automatic send_item(input swrc_pkg::func_t f, input logic [31:0] rx_tid,
                           input logic body);
    link_result_t want;
    while ($urandom_range(99) < snd_idle_pct) @(negedge clk);
    in_tuser     = f;
    in_tdata     = '0;
    in_tdata[31:0] = rx_tid;
    in_tdata[32] = body;
    in_tvalid    = 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    want = predict_link_step(f, rx_tid, body);
    awaited.push_back(want);
    n_items++;
    if (want.act == swrc_pkg::ACT_RETX) n_retx++;
    if (want.act == swrc_pkg::ACT_DROP_FULL) n_full++;
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic wait_drained();
    while (awaited.size() != 0) @(posedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(input swrc_pkg::reg_idx_t idx,
                           input logic [swrc_pkg::CFG_DATA_W-1:0] value);
    cfg_we    = 1'b1;
    cfg_addr  = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      swrc_pkg::REG_BASE_TIMEOUT: lk_base = value;
      swrc_pkg::REG_RETRY_LIMIT:  lk_retry_limit = value[7:0];
      swrc_pkg::REG_LAST_MULT:    lk_mult = value[7:0];
      default:                    lk_idle_to = value;
    endcase
  endtask

  task automatic test_directed_events();
    send_item(swrc_pkg::FUNC_DATA, 32'h0, 1'b0);
    send_item(swrc_pkg::FUNC_DATA, 32'hFFFF_FFFF, 1'b1);
    send_item(swrc_pkg::FUNC_ACK, 32'h5, 1'b0);
    send_item(swrc_pkg::FUNC_SEND, 32'hFFFF_FFFF, 1'b1);
    send_item(swrc_pkg::FUNC_ACK, 32'h0, 1'b1);
    send_item(swrc_pkg::FUNC_TICK, 32'h0, 1'b0);
    repeat (15) send_item(swrc_pkg::FUNC_SEND, $urandom, 1'($urandom_range(1)));
    // The queue now holds sixteen ids, so this request is dropped.
    send_item(swrc_pkg::FUNC_SEND, 32'h0, 1'b0);
    send_item(swrc_pkg::FUNC_ACK, front_or_random(), 1'b0);
    send_item(swrc_pkg::FUNC_ACK, 32'hFFFF_FFFF, 1'b1);
  endtask

  task automatic test_retransmit_backoff();
    wait_drained();
    write_reg(swrc_pkg::REG_BASE_TIMEOUT, 16'd2);
    write_reg(swrc_pkg::REG_RETRY_LIMIT, 16'd4);
    write_reg(swrc_pkg::REG_LAST_MULT, 16'd3);
    send_item(swrc_pkg::FUNC_ACK, front_or_random(), 1'b0);
    while (lk_sends < lk_retry_limit) begin
      send_item(swrc_pkg::FUNC_TICK, $urandom, 1'($urandom_range(1)));
    end
    send_item(swrc_pkg::FUNC_ACK, front_or_random(), 1'b1);
  endtask

  task automatic test_config_extremes();
    wait_drained();
    write_reg(swrc_pkg::REG_BASE_TIMEOUT, 16'hFFFF);
    write_reg(swrc_pkg::REG_RETRY_LIMIT, 16'd255);
    write_reg(swrc_pkg::REG_LAST_MULT, 16'd255);
    write_reg(swrc_pkg::REG_IDLE_TIMEOUT, 16'hFFFF);
    send_item(swrc_pkg::FUNC_ACK, front_or_random(), 1'b0);
    send_item(swrc_pkg::FUNC_TICK, $urandom, 1'b1);
    wait_drained();
    write_reg(swrc_pkg::REG_BASE_TIMEOUT, 16'd1);
    write_reg(swrc_pkg::REG_RETRY_LIMIT, 16'd1);
    write_reg(swrc_pkg::REG_LAST_MULT, 16'd1);
    write_reg(swrc_pkg::REG_IDLE_TIMEOUT, 16'd1);
    send_item(swrc_pkg::FUNC_ACK, front_or_random(), 1'b1);
    send_item(swrc_pkg::FUNC_DATA, $urandom, 1'b1);
  endtask

  task automatic test_random_traffic(input int n, input int snd_pct, input int rcv_pct,
                                     input logic [15:0] base, input logic [7:0] retry,
                                     input logic [7:0] mult, input logic [15:0] idle_to);
    int              pick;
    swrc_pkg::func_t f;
    logic [31:0]     tid;
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
    wait_drained();
    write_reg(swrc_pkg::REG_BASE_TIMEOUT, base);
    write_reg(swrc_pkg::REG_RETRY_LIMIT, {8'd0, retry});
    write_reg(swrc_pkg::REG_LAST_MULT, {8'd0, mult});
    write_reg(swrc_pkg::REG_IDLE_TIMEOUT, idle_to);
    repeat (n) begin
      pick = $urandom_range(99);
      tid  = $urandom;
      if (pick < 27) begin
        f = swrc_pkg::FUNC_SEND;
      end else if (pick < 57) begin
        f   = swrc_pkg::FUNC_ACK;
        tid = front_or_random();
      end else if (pick < 63) begin
        f = swrc_pkg::FUNC_ACK;
      end else if (pick < 75) begin
        f = swrc_pkg::FUNC_DATA;
      end else begin
        f = swrc_pkg::FUNC_TICK;
      end
      // A link that closes stays closed until reset, so a tick that would close it
      // is swapped for an ack of the front id.
      if (f == swrc_pkg::FUNC_TICK && tick_closes_link()) begin
        f   = swrc_pkg::FUNC_ACK;
        tid = front_or_random();
      end
      send_item(f, tid, 1'($urandom_range(1)));
    end
  endtask

  task automatic test_link_close();
    close_mode_t mode;
    logic [31:0] retx_wait;
    mode = close_mode_t'($urandom_range(3));
    wait_drained();
    write_reg(swrc_pkg::REG_BASE_TIMEOUT, 16'($urandom_range(1, 20)));
    write_reg(swrc_pkg::REG_RETRY_LIMIT,
              (mode == CLOSE_BY_RETRY) ? 16'($urandom_range(0, 4)) : 16'd255);
    write_reg(swrc_pkg::REG_LAST_MULT, 16'($urandom_range(1, 4)));
    write_reg(swrc_pkg::REG_IDLE_TIMEOUT, 16'hFFFF);
    // Empty the queue so that the next request starts with the fresh base timeout.
    send_item(swrc_pkg::FUNC_SEND, $urandom, 1'($urandom_range(1)));
    while (lk_count != 0) begin
      send_item(swrc_pkg::FUNC_ACK, lk_ids[lk_head], 1'($urandom_range(1)));
    end
    send_item(swrc_pkg::FUNC_DATA, $urandom, 1'($urandom_range(1)));
    send_item(swrc_pkg::FUNC_SEND, $urandom, 1'($urandom_range(1)));
    retx_wait = lk_retx_left;
    case (mode)
      CLOSE_BY_IDLE: begin
        close_how = "the idle timer";
        wait_drained();
        write_reg(swrc_pkg::REG_IDLE_TIMEOUT, 16'($urandom_range(0, 3)));
        send_item(swrc_pkg::FUNC_DATA, $urandom, 1'($urandom_range(1)));
      end
      CLOSE_BY_BOTH: begin
        close_how = "both timers on the same tick";
        wait_drained();
        write_reg(swrc_pkg::REG_IDLE_TIMEOUT, retx_wait[15:0]);
        send_item(swrc_pkg::FUNC_DATA, $urandom, 1'($urandom_range(1)));
      end
      CLOSE_BY_LOWERED_LIMIT: begin
        close_how = "a retry limit lowered below the send count";
        while (lk_sends < 8'd2) begin
          send_item(swrc_pkg::FUNC_TICK, $urandom, 1'($urandom_range(1)));
        end
        wait_drained();
        write_reg(swrc_pkg::REG_RETRY_LIMIT, 16'd1);
      end
      default: begin
        close_how = "the retry limit";
      end
    endcase
    while (lk_open) send_item(swrc_pkg::FUNC_TICK, $urandom, 1'($urandom_range(1)));
    repeat (24) begin
      send_item(swrc_pkg::func_t'($urandom_range(3)), $urandom, 1'($urandom_range(1)));
    end
    while (lk_retx_left != 0) begin
      send_item(swrc_pkg::FUNC_TICK, $urandom, 1'($urandom_range(1)));
    end
  endtask

  initial begin
    int spin;
    reset_link_model();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed_events();
    test_retransmit_backoff();
    test_config_extremes();
    test_random_traffic(360, 16, 81, 16'd1, 8'd255, 8'd255, 16'hFFFF);
    test_random_traffic(360, 81, 16, 16'd0, 8'($urandom_range(2, 6)), 8'd0,
                        16'($urandom_range(40, 300)));
    test_random_traffic(360, 0, 0, 16'($urandom_range(2, 12)), 8'($urandom_range(2, 8)),
                        8'($urandom_range(1, 4)), 16'($urandom_range(30, 65535)));
    test_link_close();

    spin = 0;
    while (awaited.size() != 0 && spin < 10000) begin
      @(posedge clk);
      spin++;
    end
    repeat (5) @(posedge clk);
    if (awaited.size() != 0) begin
      $error("%0d expected results never arrived", awaited.size());
      n_errors++;
    end
    $display("Sent %0d transactions and checked %0d results (%0d retransmits, %0d full drops).",
             n_items, n_checked, n_retx, n_full);
    $display("All four registers were rewritten; the link was finally closed by %s.",
             close_how);
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
